// ===== rtl/core/fre_pkg.sv =====
// Shared constants, command codes and handshake types for the flow rate estimator.
// Used by fre_div and by the top level; depends on nothing else.
`default_nettype none

package fre_pkg;

	// Field and register widths.
	localparam int RATE_W   = 32;
	localparam int COEF_W   = 16;
	localparam int TENTHS_W = 16;

	// Bit-serial divider: a 48-bit dividend (weight gain shifted by 16) gives one
	// quotient bit per step.
	localparam int DIV_STEPS = 48;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Bit-serial blend: one bit of the 17-bit coefficient pair per step.
	localparam int MUL_STEPS = COEF_W + 1;
	localparam int MUL_CNT_W = $clog2(MUL_STEPS);
	localparam int ACC_W     = RATE_W + COEF_W;

	localparam logic [COEF_W-1:0]   COEF_RESET = 16'h8000;
	localparam logic [COEF_W:0]     COEF_ONE   = 17'h10000;
	localparam logic [RATE_W-1:0]   RATE_MAX   = 32'hFFFF_FFFF;
	localparam logic [TENTHS_W-1:0] TENTHS_MAX = 16'hFFFF;
	localparam logic [ACC_W-1:0]    ACC_ROUND  = 48'h0000_0000_8000;

	// Input command codes.
	localparam logic CMD_READING = 1'b0;
	localparam logic CMD_TARE    = 1'b1;

	// Divider status toward the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/flow_rate_estimator_with_smoothing_top.sv =====
// Top level of the flow rate estimator: input sequencer, bit-serial blend and output register.
// Depends on fre_pkg and fre_div.
//
// Usage: an input transfer carries a command, a signed weight in milligrams and a
// millisecond tick. A reading yields a raw rate (gain * 65536 / elapsed ticks), blended
// with the stored smoothed rate by the smoothing coefficient, rounded to tenths of a
// gram per second. A result transfer happens only when that value differs from the
// last value sent. A tare clears the stored weight and sends nothing.
// Timing: a tare leaves in_ready high and the block idle. A reading whose weight fell, or
// whose time step is zero, skips the divider (raw rate zero or all ones) and runs only the
// 17-step blend; any other reading runs the 48-step bit-serial divider, then the blend.
// The result is registered and shows on the cycle in_ready returns.
// Stalls: the output register holds a result until out_ready; a new reading is taken
// meanwhile, and only if that reading produces a new value while the old one is still
// waiting does the block hold in_ready low until the receiver takes it.
// Reset clears the estimator state and sets the coefficient to one half. The user must write
// the coefficient via cfg_wr_en / cfg_wr_data only while idle; the block does not enforce it.
`default_nettype none

module flow_rate_estimator_with_smoothing_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [fre_pkg::COEF_W-1:0]      cfg_wr_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            command,
	input  wire logic [31:0]                     weight_mg,
	input  wire logic [31:0]                     tick_ms,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [fre_pkg::TENTHS_W-1:0]    rate_tenths
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_DIV,
		ST_MUL,
		ST_SM,
		ST_EMIT
	} state_t;

	state_t                            state_q;
	logic [fre_pkg::COEF_W-1:0]        coef_q;
	logic [fre_pkg::RATE_W-1:0]        prev_weight_q;
	logic [fre_pkg::RATE_W-1:0]        prev_tick_q;
	logic [fre_pkg::RATE_W-1:0]        smoothed_q;
	logic [fre_pkg::TENTHS_W-1:0]      last_q;
	logic [fre_pkg::TENTHS_W-1:0]      rate_q;
	logic                              out_valid_q;
	logic [fre_pkg::MUL_CNT_W-1:0]     mul_cnt_q;

	logic [fre_pkg::RATE_W-1:0]        dw_q;
	logic [fre_pkg::RATE_W-1:0]        dt_q;
	logic                              fall_q;
	logic [fre_pkg::RATE_W-1:0]        raw_q;
	logic [fre_pkg::RATE_W-1:0]        mprev_q;
	logic [fre_pkg::COEF_W:0]          ca_q;
	logic [fre_pkg::COEF_W:0]          cb_q;
	logic [fre_pkg::ACC_W-1:0]         acc_q;

	logic                              div_start;
	fre_pkg::div_status_t              div_status;
	logic [fre_pkg::RATE_W-1:0]        div_quotient;
	logic [fre_pkg::ACC_W-1:0]         sm_sum;
	logic [fre_pkg::RATE_W+4:0]        ten_sum;
	logic [fre_pkg::TENTHS_W-1:0]      tenths_w;
	logic                              bypass_div;

	// Raw rate division.
	assign bypass_div = fall_q || (dt_q == '0);
	assign div_start  = (state_q == ST_START) && !bypass_div;

	fre_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dw_q),
		.divisor  (dt_q),
		.status   (div_status),
		.quotient (div_quotient)
	);

	// Rounding of the blend and conversion to tenths (times 10 as two shifts).
	assign sm_sum   = acc_q + fre_pkg::ACC_ROUND;
	assign ten_sum  = {2'b00, smoothed_q, 3'b000} + {4'b0000, smoothed_q, 1'b0}
		+ (fre_pkg::RATE_W + 5)'(32768);
	assign tenths_w = (|ten_sum[fre_pkg::RATE_W+4:fre_pkg::RATE_W]) ? fre_pkg::TENTHS_MAX
		: ten_sum[fre_pkg::RATE_W-1:fre_pkg::TENTHS_W];

	// Coefficient register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= fre_pkg::COEF_RESET;
		end else if (cfg_wr_en) begin
			coef_q <= cfg_wr_data;
		end
	end

	// Sequencer, stored estimator state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			prev_weight_q <= '0;
			prev_tick_q   <= '0;
			smoothed_q    <= '0;
			last_q        <= '0;
			rate_q        <= '0;
			out_valid_q   <= 1'b0;
			mul_cnt_q     <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (command == fre_pkg::CMD_TARE) begin
							prev_weight_q <= '0;
						end else begin
							prev_weight_q <= weight_mg;
							prev_tick_q   <= tick_ms;
							state_q       <= ST_START;
						end
					end
				end
				ST_START: begin
					mul_cnt_q <= '0;
					state_q   <= bypass_div ? ST_MUL : ST_DIV;
				end
				ST_DIV: begin
					if (div_status.done) begin
						mul_cnt_q <= '0;
						state_q   <= ST_MUL;
					end
				end
				ST_MUL: begin
					mul_cnt_q <= mul_cnt_q + 1'b1;
					if (mul_cnt_q == fre_pkg::MUL_CNT_W'(fre_pkg::MUL_STEPS - 1)) begin
						state_q <= ST_SM;
					end
				end
				ST_SM: begin
					smoothed_q <= sm_sum[fre_pkg::ACC_W-1:fre_pkg::COEF_W];
					state_q    <= ST_EMIT;
				end
				ST_EMIT: begin
					if (tenths_w == last_q) begin
						state_q <= ST_IDLE;
					end else if (!out_valid_q || out_ready) begin
						rate_q      <= tenths_w;
						last_q      <= tenths_w;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath: weight gain, time step, raw rate and the MSB-first blend accumulator.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid && (command == fre_pkg::CMD_READING)) begin
					dw_q   <= weight_mg - prev_weight_q;
					dt_q   <= tick_ms - prev_tick_q;
					fall_q <= $signed(weight_mg) < $signed(prev_weight_q);
				end
			end
			ST_START: begin
				acc_q   <= '0;
				ca_q    <= {1'b0, coef_q};
				cb_q    <= fre_pkg::COEF_ONE - {1'b0, coef_q};
				// A falling weight drops both the history and the raw rate.
				mprev_q <= fall_q ? '0 : smoothed_q;
				raw_q   <= fall_q ? '0 : fre_pkg::RATE_MAX;
			end
			ST_DIV: begin
				if (div_status.done) begin
					raw_q <= div_quotient;
				end
			end
			ST_MUL: begin
				acc_q <= {acc_q[fre_pkg::ACC_W-2:0], 1'b0}
					+ {{fre_pkg::COEF_W{1'b0}}, (ca_q[fre_pkg::COEF_W] ? mprev_q : '0)}
					+ {{fre_pkg::COEF_W{1'b0}}, (cb_q[fre_pkg::COEF_W] ? raw_q : '0)};
				ca_q  <= {ca_q[fre_pkg::COEF_W-1:0], 1'b0};
				cb_q  <= {cb_q[fre_pkg::COEF_W-1:0], 1'b0};
			end
			default: begin
			end
		endcase
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign rate_tenths = rate_q;

	// A result only appears from the emit step.
	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("result raised outside the emit step");

	// The value on offer is always the last value reported.
	a_offer_matches_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (rate_q == last_q))
		else $error("offered result differs from last reported value");

	// The blend step counter stays within its run.
	a_mul_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (mul_cnt_q < fre_pkg::MUL_CNT_W'(fre_pkg::MUL_STEPS)))
		else $error("blend step counter out of range");

	// The divider is only waited on after it was started.
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_status.busy || div_status.done || $past(div_start)))
		else $error("waiting on an idle divider");

endmodule

`default_nettype wire

// ===== rtl/core/fre_div.sv =====
// Restoring bit-serial divider: 32-bit weight gain times 65536 over a 32-bit time step.
// Quotient saturates to all ones when it does not fit in 32 bits. Uses fre_pkg.
`default_nettype none

module fre_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [fre_pkg::RATE_W-1:0]    dividend,
	input  wire logic [fre_pkg::RATE_W-1:0]    divisor,
	output fre_pkg::div_status_t               status,
	output logic      [fre_pkg::RATE_W-1:0]    quotient
);

	typedef enum logic {
		DS_IDLE,
		DS_RUN
	} div_state_t;

	div_state_t                      state_q;
	logic [fre_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic                            done_q;
	logic [fre_pkg::RATE_W-1:0]      num_q;
	logic [fre_pkg::RATE_W-1:0]      den_q;
	logic [fre_pkg::RATE_W-1:0]      rem_q;
	logic [fre_pkg::RATE_W-1:0]      quo_q;
	logic                            ovf_q;
	logic [fre_pkg::RATE_W:0]        rem_sh;
	logic                            rem_ge;
	logic [fre_pkg::RATE_W:0]        rem_nxt;

	// One trial subtraction per cycle on the shifted partial remainder.
	assign rem_sh  = {rem_q, num_q[fre_pkg::RATE_W-1]};
	assign rem_ge  = rem_sh >= {1'b0, den_q};
	assign rem_nxt = rem_ge ? (rem_sh - {1'b0, den_q}) : rem_sh;

	// Sequencer and done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DS_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				DS_IDLE: begin
					if (start) begin
						cnt_q   <= '0;
						state_q <= DS_RUN;
					end
				end
				DS_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == fre_pkg::DIV_CNT_W'(fre_pkg::DIV_STEPS - 1)) begin
						state_q <= DS_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= DS_IDLE;
			endcase
		end
	end

	// Datapath: dividend bits enter from the top, zeros follow for the fraction bits.
	always_ff @(posedge clk) begin
		if (state_q == DS_IDLE) begin
			if (start) begin
				num_q <= dividend;
				den_q <= divisor;
				rem_q <= '0;
				quo_q <= '0;
				ovf_q <= 1'b0;
			end
		end else begin
			num_q <= {num_q[fre_pkg::RATE_W-2:0], 1'b0};
			rem_q <= rem_nxt[fre_pkg::RATE_W-1:0];
			quo_q <= {quo_q[fre_pkg::RATE_W-2:0], rem_ge};
			// A set bit pushed out of the top means the quotient overflows.
			ovf_q <= ovf_q | quo_q[fre_pkg::RATE_W-1];
		end
	end

	assign status.busy = (state_q == DS_RUN);
	assign status.done = done_q;
	assign quotient    = ovf_q ? fre_pkg::RATE_MAX : quo_q;

	// The done pulse closes a run of steps.
	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == DS_RUN))
		else $error("divider done without a preceding run");

	// The sequencer never starts a division by zero.
	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (divisor != '0))
		else $error("divider started with a zero divisor");

	// A start is only issued while the divider is free.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (state_q == DS_IDLE))
		else $error("divider started while busy");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for flow_rate_estimator_with_smoothing_top: drives readings and tares,
// predicts each rounded smoothed rate in place and compares every output transfer in order.
// Depends on fre_pkg and the top level of the block; needs no files or arguments.
`default_nettype none

module tb;

	localparam int CLK_HALF     = 10;
	localparam int RESET_CYCLES = 4;
	localparam int DRAIN_CYCLES = 100;
	localparam int HOLD_CYCLES  = 3000;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int REPORT_MAX   = 10;

	// Block ports; the driven ones are known from time zero.
	logic                         clk         = 1'b0;
	logic                         arst_n      = 1'b0;
	logic                         cfg_wr_en   = 1'b0;
	logic [fre_pkg::COEF_W-1:0]   cfg_wr_data = '0;
	logic                         in_valid    = 1'b0;
	logic                         in_ready;
	logic                         command     = fre_pkg::CMD_READING;
	logic [31:0]                  weight_mg   = '0;
	logic [31:0]                  tick_ms     = '0;
	logic                         out_valid;
	logic                         out_ready   = 1'b0;
	logic [fre_pkg::TENTHS_W-1:0] rate_tenths;

	// Predicted state of the estimator.
	logic [fre_pkg::COEF_W-1:0]   pred_coef;
	logic signed [31:0]           pred_weight;
	logic [31:0]                  pred_tick;
	logic [fre_pkg::RATE_W-1:0]   pred_smooth;
	logic [fre_pkg::TENTHS_W-1:0] pred_last;

	// Rates still owed by the block, oldest first.
	logic [fre_pkg::TENTHS_W-1:0] expected_tenths_q[$];

	int unsigned cycle_count = 0;
	int          fail_count  = 0;

	// Sender pacing.
	bit tx_idle_en  = 1'b0;
	int burst_left  = 0;

	// Receiver pacing: 0 always ready, 1 random, 2 rotating mask.
	int          rx_mode    = 0;
	logic [15:0] rx_pattern = 16'hFFFF;
	logic [3:0]  rx_phase   = '0;
	bit          hold_req   = 1'b0;
	int          hold_left  = 0;

	// Running pour used to build plausible reading sequences.
	logic signed [31:0] pour_w = '0;
	logic [31:0]        pour_t = '0;

	flow_rate_estimator_with_smoothing_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.weight_mg   (weight_mg),
		.tick_ms     (tick_ms),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.rate_tenths (rate_tenths)
	);

	// Free-running clock.
	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Compute the rate the block should report for one accepted transfer, if any.
	function automatic bit predict_rate(input logic cmd, input logic signed [31:0] w,
			input logic [31:0] t, output logic [fre_pkg::TENTHS_W-1:0] tenths_out);
		logic [63:0] raw;
		logic [63:0] prev;
		logic [63:0] dw;
		logic [63:0] sm;
		logic [63:0] tenths;
		logic [31:0] dt;
		tenths_out = '0;
		if (cmd == fre_pkg::CMD_TARE) begin
			pred_weight = '0;
			return 1'b0;
		end
		// A falling weight drops both the raw rate and the history.
		if (w < pred_weight) begin
			raw  = '0;
			prev = '0;
		end else begin
			dw = 64'(longint'(w) - longint'(pred_weight));
			dt = t - pred_tick;
			if (dt == '0) begin
				raw = 64'(fre_pkg::RATE_MAX);
			end else begin
				raw = (dw << 16) / 64'(dt);
				if (raw > 64'(fre_pkg::RATE_MAX))
					raw = 64'(fre_pkg::RATE_MAX);
			end
			prev = 64'(pred_smooth);
		end
		sm = (64'(pred_coef) * prev + (64'(fre_pkg::COEF_ONE) - 64'(pred_coef)) * raw
			+ 64'(fre_pkg::ACC_ROUND)) >> 16;
		if (sm > 64'(fre_pkg::RATE_MAX))
			sm = 64'(fre_pkg::RATE_MAX);
		pred_smooth = sm[fre_pkg::RATE_W-1:0];
		pred_weight = w;
		pred_tick   = t;
		tenths = (sm * 64'd10 + 64'(fre_pkg::ACC_ROUND)) >> 16;
		if (tenths > 64'(fre_pkg::TENTHS_MAX))
			tenths = 64'(fre_pkg::TENTHS_MAX);
		if (tenths[fre_pkg::TENTHS_W-1:0] != pred_last) begin
			pred_last  = tenths[fre_pkg::TENTHS_W-1:0];
			tenths_out = pred_last;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic note_fail(input string msg);
		fail_count++;
		if (fail_count <= REPORT_MAX)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	// Offer one input transfer, idling between bursts, and predict once it is taken.
	task automatic send_sample(input logic cmd, input logic signed [31:0] w, input logic [31:0] t);
		int gap;
		logic [fre_pkg::TENTHS_W-1:0] rate;
		if (tx_idle_en && burst_left == 0) begin
			if ($urandom_range(0, 9) == 0)
				gap = $urandom_range(20, 90);
			else
				gap = $urandom_range(1, 12);
			burst_left = $urandom_range(1, 20);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (burst_left > 0)
			burst_left--;
		in_valid  <= 1'b1;
		command   <= cmd;
		weight_mg <= w;
		tick_ms   <= t;
		do @(posedge clk); while (!in_ready);
		if (predict_rate(cmd, w, t, rate))
			expected_tenths_q.push_back(rate);
	endtask

	// Stop offering, wait for every owed rate, then let any silent item finish.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_tenths_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_coef(input logic [fre_pkg::COEF_W-1:0] value);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		pred_coef = value;
	endtask

	// Build the next item: mostly a steady pour, else a tare, drop, jump, pause or noise.
	task automatic gen_pour_item(output logic cmd, output logic signed [31:0] w,
			output logic [31:0] t);
		int sel;
		sel = $urandom_range(0, 99);
		cmd = fre_pkg::CMD_READING;
		if (sel < 78) begin
			pour_w = pour_w + 32'($urandom_range(0, 4000));
			pour_t = pour_t + 32'($urandom_range(1, 400));
		end else if (sel < 84) begin
			cmd = fre_pkg::CMD_TARE;
		end else if (sel < 88) begin
			pour_w = pour_w - 32'($urandom_range(1, 50000));
			pour_t = pour_t + 32'($urandom_range(1, 400));
		end else if (sel < 91) begin
			pour_w = pour_w + 32'($urandom_range(0, 100));
		end else if (sel < 95) begin
			pour_w = $urandom;
			pour_t = $urandom;
		end else if (sel < 97) begin
			pour_w = pour_w + 32'($urandom_range(1000000, 100000000));
			pour_t = pour_t + 32'($urandom_range(1, 3));
		end else begin
			pour_t = pour_t + 32'($urandom_range(1, 2000));
		end
		if (cmd == fre_pkg::CMD_TARE) begin
			// Payload of a tare is ignored, so let it carry noise.
			w = $urandom;
			t = $urandom;
			pour_w = '0;
		end else begin
			w = pour_w;
			t = pour_t;
		end
	endtask

	task automatic send_pour_items(input int count);
		logic               cmd;
		logic signed [31:0] w;
		logic [31:0]        t;
		repeat (count) begin
			gen_pour_item(cmd, w, t);
			send_sample(cmd, w, t);
		end
	endtask

	task automatic pick_pacing();
		tx_idle_en = ($urandom_range(0, 3) != 0);
		rx_mode    = $urandom_range(0, 2);
		rx_pattern = 16'($urandom) | 16'h0001;
	endtask

	// Receiver: a long hold-off on request, otherwise its own stall pattern.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				0: begin
					out_ready <= 1'b1;
				end
				1: begin
					out_ready <= ($urandom_range(0, 99) < 65);
				end
				default: begin
					out_ready <= rx_pattern[rx_phase];
					rx_phase  <= rx_phase + 4'd1;
				end
			endcase
		end
	end

	// Compare every output transfer with the oldest owed rate.
	always @(posedge clk) begin : check_output
		logic [fre_pkg::TENTHS_W-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_tenths_q.size() == 0) begin
				note_fail($sformatf("unexpected rate_tenths %0d", rate_tenths));
			end else begin
				want = expected_tenths_q.pop_front();
				if (rate_tenths !== want)
					note_fail($sformatf("rate_tenths expected %0d actual %0d", want, rate_tenths));
			end
		end
	end

	// Field extremes and each special case under the reset coefficient.
	task automatic test_directed();
		tx_idle_en = 1'b0;
		rx_mode    = 0;
		// Zero time step with no gain still saturates the raw rate.
		send_sample(fre_pkg::CMD_READING, 32'sd0, 32'd0);
		// Largest gain in one tick: oversized rate.
		send_sample(fre_pkg::CMD_READING, 32'sh7FFF_FFFF, 32'd1);
		// Fall to the most negative weight clears the smoothed rate.
		send_sample(fre_pkg::CMD_READING, 32'sh8000_0000, 32'd2);
		send_sample(fre_pkg::CMD_READING, 32'sh8000_0000, 32'd5);
		send_sample(fre_pkg::CMD_TARE, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
		// Steady one gram per second after the tare.
		send_sample(fre_pkg::CMD_READING, 32'sd1000, 32'd1005);
		send_sample(fre_pkg::CMD_READING, 32'sd2000, 32'd2005);
		send_sample(fre_pkg::CMD_READING, 32'sd3000, 32'd3005);
		// No gain, so the rate decays.
		send_sample(fre_pkg::CMD_READING, 32'sd3000, 32'd4005);
		// Tick wraps through its maximum.
		send_sample(fre_pkg::CMD_READING, 32'sd5000, 32'hFFFF_FFFF);
		send_sample(fre_pkg::CMD_READING, 32'sd9000, 32'h0000_0F9F);
		// Same tick and same weight again.
		send_sample(fre_pkg::CMD_READING, 32'sd9000, 32'h0000_0F9F);
		send_sample(fre_pkg::CMD_TARE, 32'sd0, 32'd0);
		// Just below zero after a tare counts as a fall.
		send_sample(fre_pkg::CMD_READING, -32'sd1, 32'h0000_1000);
		// A further fall to a negative weight, then a gain across zero.
		send_sample(fre_pkg::CMD_READING, -32'sd5000, 32'h0000_1100);
		send_sample(fre_pkg::CMD_READING, 32'sd5000, 32'h0000_1180);
		send_sample(fre_pkg::CMD_READING, 32'sh7FFF_FFFF, 32'h8000_0000);
		send_sample(fre_pkg::CMD_READING, 32'sh7FFF_FFFF, 32'h8000_0001);
	endtask

	// Coefficient extremes and a few settings between them.
	task automatic test_coef_extremes();
		logic [fre_pkg::COEF_W-1:0] coefs[5];
		coefs[0] = '0;
		coefs[1] = '1;
		coefs[2] = 16'd1;
		coefs[3] = 16'hFFFE;
		coefs[4] = 16'($urandom);
		foreach (coefs[i]) begin
			write_coef(coefs[i]);
			pick_pacing();
			send_sample(fre_pkg::CMD_READING, pour_w + 32'sd2500, pour_t + 32'd100);
			pour_w = pour_w + 32'sd2500;
			pour_t = pour_t + 32'd100;
			send_pour_items(9);
		end
	endtask

	// Receiver holds off while readings keep arriving, so the block must stall its input.
	task automatic test_backpressure();
		write_coef(fre_pkg::COEF_RESET);
		tx_idle_en = 1'b0;
		rx_mode    = 0;
		hold_req   = 1'b1;
		for (int k = 1; k <= 12; k++) begin
			pour_w = pour_w + 32'(k * 700);
			pour_t = pour_t + 32'd100;
			send_sample(fre_pkg::CMD_READING, pour_w, pour_t);
		end
	endtask

	// Sender stops until every owed rate has come, then resumes.
	task automatic test_drain_pause();
		pick_pacing();
		send_pour_items(8);
		wait_idle();
		send_pour_items(8);
	endtask

	// Long random run in segments, each with its own coefficient and fresh pacing per block.
	task automatic test_random();
		for (int seg = 0; seg < 4; seg++) begin
			write_coef(16'($urandom));
			for (int blk = 0; blk < 4; blk++) begin
				pick_pacing();
				send_pour_items(35);
			end
		end
	endtask

	// Reset, the tests in turn, then the final check.
	initial begin
		pred_coef   = fre_pkg::COEF_RESET;
		pred_weight = '0;
		pred_tick   = '0;
		pred_smooth = '0;
		pred_last   = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_coef_extremes();
		test_backpressure();
		test_drain_pause();
		test_random();

		wait_idle();
		if (expected_tenths_q.size() != 0)
			note_fail($sformatf("%0d rates never arrived", expected_tenths_q.size()));
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
